// ===== hw/rtl/ep0_pkg.sv =====
// shared types, constants and codes for the endpoint-0 control sequencer
// no dependencies; used by every module under hw/rtl

package ep0_pkg;

    // sizing of the endpoint
    localparam int MAX_PACKET   = 64;
    localparam int BUFFER_BYTES = 128;

    // depth of the command queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // input item kinds
    localparam logic [1:0] KIND_SETUP   = 2'd0;
    localparam logic [1:0] KIND_OUT     = 2'd1;
    localparam logic [1:0] KIND_TX_FREE = 2'd2;
    localparam logic [1:0] KIND_REPLY   = 2'd3;

    // result actions
    localparam logic [2:0] ACT_ACCEPT  = 3'd0;
    localparam logic [2:0] ACT_DISCARD = 3'd1;
    localparam logic [2:0] ACT_SEND    = 3'd2;
    localparam logic [2:0] ACT_STALL   = 3'd3;
    localparam logic [2:0] ACT_READY   = 3'd4;

    // one input event
    typedef struct packed {
        logic [1:0]  kind;
        logic        setup_direction_in;
        logic [15:0] setup_length;
        logic [6:0]  out_length;
        logic        tx_free;
        logic        handled;
        logic [7:0]  reply_length;
    } item_t;

    // one result transaction
    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  offset;
        logic [15:0] length;
        logic        last;
    } result_t;

    // result body without the last flag
    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  offset;
        logic [15:0] length;
    } res_body_t;

    // queued command: one or two results caused by one item
    typedef struct packed {
        logic      two;
        res_body_t r0;
        res_body_t r1;
    } cmd_t;

endpackage

// ===== hw/rtl/ep0_front.sv =====
// front end: takes input events, keeps the control transfer state and
// turns each event that causes results into a queued command; depends on ep0_pkg

module ep0_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  ep0_pkg::item_t  item,
    output logic            push,
    output ep0_pkg::cmd_t   push_cmd,
    input  logic            full
);

    localparam logic [16:0] BUF17  = 17'(ep0_pkg::BUFFER_BYTES);
    localparam logic [15:0] BUF16  = 16'(ep0_pkg::BUFFER_BYTES);
    localparam logic [7:0]  MAXP8  = 8'(ep0_pkg::MAX_PACKET);

    logic        done_reg,  done_next;
    logic [16:0] rcount_reg, rcount_next;
    logic        dir_reg,   dir_next;
    logic [15:0] rlen_reg,  rlen_next;
    logic        sact_reg,  sact_next;
    logic [7:0]  srem_reg,  srem_next;
    logic [7:0]  soff_reg,  soff_next;
    logic        trunc_reg, trunc_next;
    logic        pend_reg,  pend_next;

    logic        accept;
    logic        send_try;
    logic [1:0]  nres;
    logic [16:0] room;
    logic [6:0]  take;
    logic [16:0] sum;
    logic [7:0]  clip;
    logic [7:0]  plen;
    ep0_pkg::res_body_t r0, r1;

    assign item_stall = full;
    assign accept     = item_valid && !full;

    // classify the event and work out the next transfer state
    always_comb
    begin
        done_next   = done_reg;
        rcount_next = rcount_reg;
        dir_next    = dir_reg;
        rlen_next   = rlen_reg;
        sact_next   = sact_reg;
        srem_next   = srem_reg;
        soff_next   = soff_reg;
        trunc_next  = trunc_reg;
        pend_next   = pend_reg;
        nres        = 2'd0;
        r0          = '0;
        r1          = '0;
        send_try    = 1'b0;
        room        = BUF17 - rcount_reg;
        take        = '0;
        sum         = rcount_reg + {10'd0, item.out_length};
        clip        = (item.reply_length > BUF16[7:0] && ep0_pkg::BUFFER_BYTES < 256)
                      ? BUF16[7:0] : item.reply_length;
        plen        = '0;

        case (item.kind)
            ep0_pkg::KIND_SETUP:
            begin
                done_next   = 1'b0;
                rcount_next = '0;
                sact_next   = 1'b0;
                pend_next   = 1'b0;
                dir_next    = item.setup_direction_in;
                rlen_next   = item.setup_length;
                if (item.setup_direction_in || item.setup_length == 16'd0)
                begin
                    nres = 2'd1;
                    if (!item.setup_direction_in && item.setup_length > BUF16)
                    begin
                        r0.action = ep0_pkg::ACT_STALL;
                        done_next = 1'b1;
                        pend_next = 1'b0;
                    end
                    else
                    begin
                        r0.action = ep0_pkg::ACT_READY;
                        pend_next = 1'b1;
                    end
                end
            end
            ep0_pkg::KIND_OUT:
            begin
                if (done_reg)
                begin
                    // unexpected data after the transfer ended
                    nres      = 2'd2;
                    r0.action = ep0_pkg::ACT_STALL;
                    r1.action = ep0_pkg::ACT_DISCARD;
                end
                else if (!dir_reg)
                begin
                    // out data stage, bytes past the buffer are counted only
                    if (rcount_reg < BUF17)
                    begin
                        take = (room < {10'd0, item.out_length})
                               ? room[6:0] : item.out_length;
                    end
                    nres      = 2'd1;
                    r0.action = ep0_pkg::ACT_ACCEPT;
                    r0.offset = rcount_reg[7:0];
                    r0.length = {9'd0, take};
                    rcount_next = sum;
                    if (sum >= {1'b0, rlen_reg})
                    begin
                        rcount_next = {1'b0, rlen_reg};
                        nres        = 2'd2;
                        if (rlen_reg > BUF16)
                        begin
                            r1.action = ep0_pkg::ACT_STALL;
                            done_next = 1'b1;
                            pend_next = 1'b0;
                        end
                        else
                        begin
                            r1.action = ep0_pkg::ACT_READY;
                            r1.length = rlen_reg;
                            pend_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    // status packet from host ends an in transfer
                    nres      = 2'd1;
                    r0.action = ep0_pkg::ACT_DISCARD;
                    sact_next = 1'b0;
                    pend_next = 1'b0;
                    done_next = 1'b1;
                end
            end
            ep0_pkg::KIND_TX_FREE:
            begin
                send_try = 1'b1;
            end
            ep0_pkg::KIND_REPLY:
            begin
                if (pend_reg)
                begin
                    pend_next = 1'b0;
                    if (!item.handled)
                    begin
                        nres      = 2'd1;
                        r0.action = ep0_pkg::ACT_STALL;
                        done_next = 1'b1;
                    end
                    else if (dir_reg)
                    begin
                        // clip reply to the buffer and to wLength
                        if ({8'd0, clip} > rlen_reg)
                        begin
                            clip = rlen_reg[7:0];
                        end
                        soff_next  = '0;
                        srem_next  = clip;
                        trunc_next = ({8'd0, clip} < rlen_reg);
                        sact_next  = 1'b1;
                        send_try   = 1'b1;
                    end
                    else
                    begin
                        // zero-length status packet
                        soff_next  = '0;
                        srem_next  = '0;
                        trunc_next = 1'b0;
                        sact_next  = 1'b1;
                        send_try   = 1'b1;
                        done_next  = 1'b1;
                    end
                end
            end
            default:
            begin
                nres = 2'd0;
            end
        endcase

        // packet send when the transmitter has room
        if (send_try && sact_next && item.tx_free)
        begin
            plen      = (srem_next < MAXP8) ? srem_next : MAXP8;
            nres      = 2'd1;
            r0.action = ep0_pkg::ACT_SEND;
            r0.offset = soff_next;
            r0.length = {8'd0, plen};
            soff_next = soff_next + plen;
            srem_next = srem_next - plen;
            if (srem_next == 8'd0 && (!trunc_next || plen < MAXP8))
            begin
                sact_next = 1'b0;
            end
        end
    end

    assign push         = accept && (nres != 2'd0);
    assign push_cmd.two = (nres == 2'd2);
    assign push_cmd.r0  = r0;
    assign push_cmd.r1  = r1;

    // transfer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            rcount_reg <= '0;
            dir_reg    <= 1'b0;
            rlen_reg   <= '0;
            sact_reg   <= 1'b0;
            srem_reg   <= '0;
            soff_reg   <= '0;
            trunc_reg  <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else if (accept)
        begin
            done_reg   <= done_next;
            rcount_reg <= rcount_next;
            dir_reg    <= dir_next;
            rlen_reg   <= rlen_next;
            sact_reg   <= sact_next;
            srem_reg   <= srem_next;
            soff_reg   <= soff_next;
            trunc_reg  <= trunc_next;
            pend_reg   <= pend_next;
        end
    end

endmodule

// ===== hw/rtl/ep0_cmd_fifo.sv =====
// short command queue between the front end and the back end
// depends on ep0_pkg for the command type and depth

module ep0_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ep0_pkg::cmd_t  push_cmd,
    output logic           full,
    input  logic           pop,
    output ep0_pkg::cmd_t  pop_cmd,
    output logic           empty
);

    localparam logic [ep0_pkg::FIFO_AW:0] DEPTH = (ep0_pkg::FIFO_AW + 1)'(ep0_pkg::FIFO_DEPTH);

    ep0_pkg::cmd_t                 slot_reg [ep0_pkg::FIFO_DEPTH];
    logic [ep0_pkg::FIFO_AW-1:0]   wptr_reg, wptr_next;
    logic [ep0_pkg::FIFO_AW-1:0]   rptr_reg, rptr_next;
    logic [ep0_pkg::FIFO_AW:0]     count_reg, count_next;

    assign full    = (count_reg == DEPTH);
    assign empty   = (count_reg == '0);
    assign pop_cmd = slot_reg[rptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == ep0_pkg::FIFO_AW'(ep0_pkg::FIFO_DEPTH - 1))
                        ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == ep0_pkg::FIFO_AW'(ep0_pkg::FIFO_DEPTH - 1))
                        ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hw/rtl/ep0_back.sv =====
// back end: unpacks queued commands into result transactions and holds
// the output register; depends on ep0_pkg

module ep0_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             empty,
    input  ep0_pkg::cmd_t    pop_cmd,
    output logic             pop,
    output logic             result_valid,
    input  logic             result_stall,
    output ep0_pkg::result_t result
);

    logic                 valid_reg, valid_next;
    logic                 second_reg, second_next;
    ep0_pkg::result_t     out_reg, out_next;
    ep0_pkg::res_body_t   held_reg, held_next;
    logic                 load;

    assign load         = !valid_reg || !result_stall;
    assign result_valid = valid_reg;
    assign result       = out_reg;

    // pick the next result: held second one first, then the queue head
    always_comb
    begin
        pop         = 1'b0;
        valid_next  = valid_reg;
        second_next = second_reg;
        out_next    = out_reg;
        held_next   = held_reg;
        if (load)
        begin
            if (second_reg)
            begin
                out_next    = {held_reg, 1'b1};
                valid_next  = 1'b1;
                second_next = 1'b0;
            end
            else if (!empty)
            begin
                pop         = 1'b1;
                out_next    = {pop_cmd.r0, !pop_cmd.two};
                valid_next  = 1'b1;
                second_next = pop_cmd.two;
                held_next   = pop_cmd.r1;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        held_reg <= held_next;
    end

endmodule

// ===== hw/rtl/usb_ep0_control_sequencer.sv =====
// top level of the usb endpoint-0 control transfer sequencer
// depends on ep0_pkg, ep0_front, ep0_cmd_fifo and ep0_back

// Events (setup, OUT packet, transmit free, handler reply) are taken one per
// clock while the four-entry command queue has room; the front end updates the
// transfer state in the same cycle and queues the one or two results an event
// causes. The back end sends one result transaction per clock from its output
// register while the receiver does not stall, so an event with two results
// leaves it as two transactions in turn. A result passes the queue write and
// then the output register before it appears. Stall on the event side rises
// only when the queue is full. No clearing pass is needed after reset.

module usb_ep0_control_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  ep0_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output ep0_pkg::result_t result
);

    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    ep0_pkg::cmd_t push_cmd;
    ep0_pkg::cmd_t pop_cmd;

    ep0_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full)
    );

    ep0_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (empty)
    );

    ep0_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .pop_cmd      (pop_cmd),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== verif/tb_usb_ep0_control_sequencer.sv =====
// testbench for the usb endpoint-0 control transfer sequencer
// drives directed and random event transactions, checks results against a local predictor
// depends on ep0_pkg and usb_ep0_control_sequencer

`timescale 1ns / 100ps

module tb_usb_ep0_control_sequencer;

    import ep0_pkg::*;

    localparam int RANDOM_ITEMS   = 500;
    localparam int STEADY_ITEMS   = 60;
    localparam int LONG_HOLD      = 60;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    // one row of the directed table; typed_count < 0 means use the predictor
    typedef struct {
        item_t   ev;
        int      typed_count;
        result_t r0;
        result_t r1;
    } dir_row_t;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // predictor copy of the transfer state
    logic        done_q         = 1'b0;
    logic [16:0] rx_count       = '0;
    logic        dir_in         = 1'b0;
    logic [15:0] req_len        = '0;
    logic        sending        = 1'b0;
    logic [7:0]  tx_left        = '0;
    logic [7:0]  tx_off         = '0;
    logic        short_reply    = 1'b0;
    logic        awaiting_reply = 1'b0;

    result_t  event_cmds[$];
    result_t  cmds_due[$];
    dir_row_t directed_rows[$];

    int  errors        = 0;
    int  items_sent    = 0;
    int  stuck_cycles  = 0;
    int  hold_left     = 0;
    int  burst_left    = 0;
    logic hold_req     = 1'b0;
    logic hold_done    = 1'b0;
    logic steady_phase = 1'b0;
    logic no_gaps      = 1'b0;

    usb_ep0_control_sequencer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #10 clk = ~clk;

    function automatic item_t mk_item(logic [1:0] k, logic d, logic [15:0] sl, logic [6:0] ol,
                                      logic tf, logic h, logic [7:0] rl);
        item_t ev;
        ev.kind               = k;
        ev.setup_direction_in = d;
        ev.setup_length       = sl;
        ev.out_length         = ol;
        ev.tx_free            = tf;
        ev.handled            = h;
        ev.reply_length       = rl;
        return ev;
    endfunction

    function automatic result_t mk_res(logic [2:0] act, logic [7:0] off, logic [15:0] len,
                                       logic lst);
        result_t r;
        r.action = act;
        r.offset = off;
        r.length = len;
        r.last   = lst;
        return r;
    endfunction

    function automatic void add_row(item_t ev, int n, result_t r0, result_t r1);
        dir_row_t row;
        row.ev          = ev;
        row.typed_count = n;
        row.r0          = r0;
        row.r1          = r1;
        directed_rows.push_back(row);
    endfunction

    // event with every field random inside its range
    function automatic item_t rand_item();
        item_t ev;
        ev.kind               = 2'($urandom_range(0, 3));
        ev.setup_direction_in = 1'($urandom_range(0, 1));
        ev.setup_length       = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                            : 16'($urandom_range(0, 200));
        ev.out_length         = 7'($urandom_range(0, 64));
        ev.tx_free            = 1'($urandom_range(0, 1));
        ev.handled            = 1'($urandom_range(0, 1));
        ev.reply_length       = 8'($urandom_range(0, 128));
        return ev;
    endfunction

    function automatic void emit_cmd(logic [2:0] act, logic [7:0] off, logic [15:0] len);
        event_cmds.push_back(mk_res(act, off, len, 1'b0));
    endfunction

    // one IN packet when a send is under way and the transmitter is free
    function automatic void try_transmit(logic txf);
        int len;
        if (!sending || !txf)
            return;
        len = (int'(tx_left) < MAX_PACKET) ? int'(tx_left) : MAX_PACKET;
        emit_cmd(ACT_SEND, tx_off, 16'(len));
        tx_off  = tx_off + 8'(len);
        tx_left = tx_left - 8'(len);
        if (tx_left == 8'd0 && (!short_reply || len < MAX_PACKET))
            sending = 1'b0;
    endfunction

    // request complete: notify the handler, or stall an oversized OUT request
    function automatic void finish_request();
        if (!dir_in && int'(req_len) > BUFFER_BYTES)
        begin
            emit_cmd(ACT_STALL, 8'd0, 16'd0);
            done_q         = 1'b1;
            awaiting_reply = 1'b0;
        end
        else
        begin
            emit_cmd(ACT_READY, 8'd0, rx_count[15:0]);
            awaiting_reply = 1'b1;
        end
    endfunction

    // advance the predicted transfer by one event, results land in event_cmds
    function automatic void advance_transfer(item_t ev);
        int      take;
        int      len;
        result_t tail;
        event_cmds.delete();
        case (ev.kind)
            KIND_SETUP:
            begin
                done_q         = 1'b0;
                rx_count       = '0;
                sending        = 1'b0;
                awaiting_reply = 1'b0;
                dir_in         = ev.setup_direction_in;
                req_len        = ev.setup_length;
                if (dir_in || req_len == 16'd0)
                    finish_request();
            end
            KIND_OUT:
            begin
                if (done_q)
                begin
                    emit_cmd(ACT_STALL, 8'd0, 16'd0);
                    emit_cmd(ACT_DISCARD, 8'd0, 16'd0);
                end
                else if (!dir_in)
                begin
                    take = 0;
                    if (int'(rx_count) < BUFFER_BYTES)
                    begin
                        take = BUFFER_BYTES - int'(rx_count);
                        if (take > int'(ev.out_length))
                            take = int'(ev.out_length);
                    end
                    emit_cmd(ACT_ACCEPT, rx_count[7:0], 16'(take));
                    rx_count = rx_count + 17'(ev.out_length);
                    if (rx_count >= 17'(req_len))
                    begin
                        rx_count = 17'(req_len);
                        finish_request();
                    end
                end
                else
                begin
                    // status stage from host ends the IN transfer
                    emit_cmd(ACT_DISCARD, 8'd0, 16'd0);
                    sending        = 1'b0;
                    awaiting_reply = 1'b0;
                    done_q         = 1'b1;
                end
            end
            KIND_TX_FREE:
            begin
                try_transmit(ev.tx_free);
            end
            default:
            begin
                // stray replies fall through untouched
                if (awaiting_reply)
                begin
                    awaiting_reply = 1'b0;
                    if (!ev.handled)
                    begin
                        emit_cmd(ACT_STALL, 8'd0, 16'd0);
                        done_q = 1'b1;
                    end
                    else if (dir_in)
                    begin
                        len = int'(ev.reply_length);
                        if (len > BUFFER_BYTES)
                            len = BUFFER_BYTES;
                        if (len > int'(req_len))
                            len = int'(req_len);
                        tx_off      = 8'd0;
                        tx_left     = 8'(len);
                        short_reply = (len < int'(req_len));
                        sending     = 1'b1;
                        try_transmit(ev.tx_free);
                    end
                    else
                    begin
                        // zero-length status packet for an OUT transfer
                        tx_off      = 8'd0;
                        tx_left     = 8'd0;
                        short_reply = 1'b0;
                        sending     = 1'b1;
                        try_transmit(ev.tx_free);
                        done_q = 1'b1;
                    end
                end
            end
        endcase
        if (event_cmds.size() > 0)
        begin
            tail      = event_cmds.pop_back();
            tail.last = 1'b1;
            event_cmds.push_back(tail);
        end
    endfunction

    // offer one event, predict on acceptance, then maybe leave a gap
    task automatic send_item(input item_t ev, input int typed_count, input result_t r0,
                             input result_t r1);
        int gap;
        @(negedge clk);
        item_valid <= 1'b1;
        item       <= ev;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        advance_transfer(ev);
        items_sent++;
        if (typed_count < 0)
        begin
            foreach (event_cmds[i])
                cmds_due.push_back(event_cmds[i]);
        end
        else
        begin
            if (typed_count > 0)
                cmds_due.push_back(r0);
            if (typed_count > 1)
                cmds_due.push_back(r1);
        end
        if (!steady_phase && !no_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            @(negedge clk);
            item_valid <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    // receiver stall: random bursts, one long hold-off on request, none at the end
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            result_stall <= 1'b1;
            hold_left    <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            result_stall <= 1'b1;
            hold_left    <= LONG_HOLD;
            hold_done    <= 1'b1;
        end
        else if (steady_phase)
        begin
            result_stall <= 1'b0;
        end
        else if (burst_left != 0)
        begin
            burst_left <= burst_left - 1;
        end
        else if ($urandom_range(0, 2) == 0)
        begin
            result_stall <= 1'b1;
            burst_left   <= $urandom_range(0, 9);
        end
        else
        begin
            result_stall <= 1'b0;
            burst_left   <= $urandom_range(0, 29);
        end
    end

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // compare each result transaction with the oldest expected one
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (cmds_due.size() == 0)
            begin
                $display("%0t ns: result with nothing expected, action %0d offset %0d length %0d",
                         $time, result.action, result.offset, result.length);
                errors++;
            end
            else
            begin
                want = cmds_due.pop_front();
                check_field("action", 16'(want.action), 16'(result.action));
                check_field("offset", 16'(want.offset), 16'(result.offset));
                check_field("length", want.length, result.length);
                check_field("last", 16'(want.last), 16'(result.last));
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
            begin
                stuck_cycles = 0;
            end
            else
            begin
                stuck_cycles++;
                if (stuck_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("%0t ns: no progress, %0d results still expected", $time,
                             cmds_due.size());
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        item_t ev;
        int    start;
        int    len;
        int    got;
        int    npk;
        int    k;
        logic  d;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        repeat (4)
            @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        add_row(mk_item(KIND_REPLY, 1'b0, 16'd0, 7'd0, 1'b1, 1'b1, 8'd128), 0, '0, '0);
        add_row(mk_item(KIND_TX_FREE, 1'b0, 16'd0, 7'd0, 1'b1, 1'b0, 8'd0), 0, '0, '0);
        add_row(mk_item(KIND_SETUP, 1'b1, 16'hFFFF, 7'd0, 1'b0, 1'b0, 8'd0), 1,
                mk_res(ACT_READY, 8'd0, 16'd0, 1'b1), '0);
        // truncated reply, transmitter busy
        add_row(mk_item(KIND_REPLY, 1'b0, 16'd0, 7'd0, 1'b0, 1'b1, 8'd128), -1, '0, '0);
        add_row(mk_item(KIND_TX_FREE, 1'b0, 16'd0, 7'd0, 1'b1, 1'b0, 8'd0), -1, '0, '0);
        add_row(mk_item(KIND_TX_FREE, 1'b0, 16'd0, 7'd0, 1'b0, 1'b0, 8'd0), -1, '0, '0);
        add_row(mk_item(KIND_TX_FREE, 1'b0, 16'd0, 7'd0, 1'b1, 1'b0, 8'd0), -1, '0, '0);
        // zero-length packet after a full last packet
        add_row(mk_item(KIND_TX_FREE, 1'b0, 16'd0, 7'd0, 1'b1, 1'b0, 8'd0), -1, '0, '0);
        // status from host, then unexpected OUT
        add_row(mk_item(KIND_OUT, 1'b0, 16'd0, 7'd0, 1'b0, 1'b0, 8'd0), 1,
                mk_res(ACT_DISCARD, 8'd0, 16'd0, 1'b1), '0);
        add_row(mk_item(KIND_OUT, 1'b0, 16'd0, 7'd64, 1'b0, 1'b0, 8'd0), 2,
                mk_res(ACT_STALL, 8'd0, 16'd0, 1'b0), mk_res(ACT_DISCARD, 8'd0, 16'd0, 1'b1));
        // OUT request longer than the buffer: overflow, offset wrap, stall
        add_row(mk_item(KIND_SETUP, 1'b0, 16'd300, 7'd0, 1'b0, 1'b0, 8'd0), -1, '0, '0);
        repeat (5)
            add_row(mk_item(KIND_OUT, 1'b0, 16'd0, 7'd64, 1'b0, 1'b0, 8'd0), -1, '0, '0);
        add_row(mk_item(KIND_REPLY, 1'b0, 16'd0, 7'd0, 1'b1, 1'b1, 8'd0), 0, '0, '0);
        // zero-length OUT request refused by the handler
        add_row(mk_item(KIND_SETUP, 1'b0, 16'd0, 7'd0, 1'b0, 1'b0, 8'd0), 1,
                mk_res(ACT_READY, 8'd0, 16'd0, 1'b1), '0);
        add_row(mk_item(KIND_REPLY, 1'b0, 16'd0, 7'd0, 1'b1, 1'b0, 8'd0), 1,
                mk_res(ACT_STALL, 8'd0, 16'd0, 1'b1), '0);
        // OUT request with repeated data, then status packet
        add_row(mk_item(KIND_SETUP, 1'b0, 16'd100, 7'd0, 1'b0, 1'b0, 8'd0), -1, '0, '0);
        add_row(mk_item(KIND_OUT, 1'b0, 16'd0, 7'd64, 1'b0, 1'b0, 8'd0), -1, '0, '0);
        add_row(mk_item(KIND_OUT, 1'b0, 16'd0, 7'd40, 1'b0, 1'b0, 8'd0), -1, '0, '0);
        add_row(mk_item(KIND_OUT, 1'b0, 16'd0, 7'd10, 1'b0, 1'b0, 8'd0), -1, '0, '0);
        add_row(mk_item(KIND_REPLY, 1'b0, 16'd0, 7'd0, 1'b1, 1'b1, 8'd0), -1, '0, '0);
        // IN reply clipped to wLength
        add_row(mk_item(KIND_SETUP, 1'b1, 16'd10, 7'd0, 1'b0, 1'b0, 8'd0), -1, '0, '0);
        add_row(mk_item(KIND_REPLY, 1'b0, 16'd0, 7'd0, 1'b1, 1'b1, 8'd128), -1, '0, '0);

        foreach (directed_rows[i])
            send_item(directed_rows[i].ev, directed_rows[i].typed_count,
                      directed_rows[i].r0, directed_rows[i].r1);

        // random part: mostly well-formed transfers, some noise
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            if (items_sent - start >= RANDOM_ITEMS - STEADY_ITEMS)
                steady_phase = 1'b1;
            if (!hold_done && items_sent - start >= 150)
            begin
                // long receiver hold-off while events keep coming
                hold_req = 1'b1;
                // drop valid so the last transaction is not taken twice while waiting
                @(negedge clk);
                item_valid <= 1'b0;
                wait (hold_left != 0);
                no_gaps = 1'b1;
                ev = rand_item();
                ev.kind = KIND_SETUP;
                ev.setup_direction_in = 1'b1;
                send_item(ev, -1, '0, '0);
                repeat (11)
                begin
                    ev = rand_item();
                    ev.kind = KIND_OUT;
                    send_item(ev, -1, '0, '0);
                end
                no_gaps = 1'b0;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                k = $urandom_range(1, 4);
                repeat (k)
                    send_item(rand_item(), -1, '0, '0);
            end
            else
            begin
                d = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 9))
                    0:       len = $urandom_range(0, 65535);
                    1, 2:    len = $urandom_range(129, 400);
                    default: len = $urandom_range(0, 160);
                endcase
                ev = rand_item();
                ev.kind               = KIND_SETUP;
                ev.setup_direction_in = d;
                ev.setup_length       = 16'(len);
                send_item(ev, -1, '0, '0);
                // OUT data stage
                if (!d)
                begin
                    got = 0;
                    npk = 0;
                    while (got < len && npk < 8)
                    begin
                        ev = rand_item();
                        ev.kind       = KIND_OUT;
                        ev.out_length = ($urandom_range(0, 1) == 1) ? 7'd64
                                                                    : 7'($urandom_range(0, 64));
                        got += int'(ev.out_length);
                        npk++;
                        send_item(ev, -1, '0, '0);
                    end
                end
                // handler reply
                if ($urandom_range(0, 9) != 0)
                begin
                    ev = rand_item();
                    ev.kind    = KIND_REPLY;
                    ev.handled = ($urandom_range(0, 6) != 0);
                    ev.tx_free = ($urandom_range(0, 3) != 0);
                    if ($urandom_range(0, 2) == 0)
                        ev.reply_length = 8'($urandom_range(0, 2) * MAX_PACKET);
                    send_item(ev, -1, '0, '0);
                end
                // transmit free events for the IN data stage
                k = d ? $urandom_range(0, 4) : $urandom_range(0, 1);
                repeat (k)
                begin
                    ev = rand_item();
                    ev.kind    = KIND_TX_FREE;
                    ev.tx_free = ($urandom_range(0, 3) != 0);
                    send_item(ev, -1, '0, '0);
                end
                // status stage from host
                if (d && $urandom_range(0, 9) != 0)
                begin
                    ev = rand_item();
                    ev.kind = KIND_OUT;
                    if ($urandom_range(0, 4) != 0)
                        ev.out_length = 7'd0;
                    send_item(ev, -1, '0, '0);
                end
            end
        end

        @(negedge clk);
        item_valid <= 1'b0;
        while (cmds_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (errors == 0 && cmds_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
